// ----- rtl/cbpm_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cbpm_pkg
// shared types and constants of the cursor buffer with prefix max sum query
// ----------------------------------------------------------------------------
package cbpm_pkg;

  localparam int CAPACITY = 1024;
  localparam int CNT_W    = $clog2(CAPACITY + 1);
  localparam int ADDR_W   = $clog2(CAPACITY);

  localparam int REQ_W  = 3;
  localparam int VAL_W  = 32;
  localparam int LEN_W  = 11;
  localparam int SUM_W  = 64;
  localparam int STAT_W = 2;

  localparam logic signed [SUM_W-1:0] SUM_MIN = {1'b1, {(SUM_W-1){1'b0}}};

  typedef enum logic [REQ_W-1:0] {
    REQ_INSERT = 3'd0,
    REQ_DELETE = 3'd1,
    REQ_LEFT   = 3'd2,
    REQ_RIGHT  = 3'd3,
    REQ_QUERY  = 3'd4
  } req_type_e;

  typedef enum logic [STAT_W-1:0] {
    STAT_OK    = 2'd0,
    STAT_RANGE = 2'd1,
    STAT_FULL  = 2'd2
  } status_e;

  typedef enum logic {
    S_IDLE,
    S_EXEC
  } state_e;

  // one prefix table row: running sum and running max of the sums
  typedef struct packed {
    logic signed [SUM_W-1:0] sum;
    logic signed [SUM_W-1:0] max;
  } prefix_t;

  localparam int PREFIX_W = $bits(prefix_t);

endpackage

// ----- rtl/cbpm_req_if.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cbpm_req_if
// request channel: operation code, inserted value and query length
// ----------------------------------------------------------------------------
interface cbpm_req_if
  import cbpm_pkg::*;
();
  logic             valid;
  logic             ready;
  logic [REQ_W-1:0] req_type;
  logic [VAL_W-1:0] value;
  logic [LEN_W-1:0] prefix_len;

  modport source (output valid, req_type, value, prefix_len, input ready);
  modport sink   (input valid, req_type, value, prefix_len, output ready);
endinterface

// ----- rtl/cbpm_res_if.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cbpm_res_if
// result channel: query answer and status
// ----------------------------------------------------------------------------
interface cbpm_res_if
  import cbpm_pkg::*;
();
  logic                    valid;
  logic                    ready;
  logic signed [SUM_W-1:0] max_prefix_sum;
  logic [STAT_W-1:0]       status;

  modport source (output valid, max_prefix_sum, status, input ready);
  modport sink   (input valid, max_prefix_sum, status, output ready);
endinterface

// ----- rtl/cursor_buffer_prefix_max_sum.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cursor_buffer_prefix_max_sum
// cursor sequence editor held as two stacks with a prefix max sum query
// ----------------------------------------------------------------------------
// Each request has an accept and an execute step: in the accept cycle the
// stack tops and the prefix row are addressed in the rams (registered read
// ports), in the following cycle the block computes, writes back, moves the
// counts and loads the result register. A request that yields a result while
// the previous result is still waiting stays in the execute state until the
// output register frees; a new request is accepted only once the block is
// back in idle. Three rams hold the state: left stack and right stack
// (CAPACITY x 32) and the prefix table (CAPACITY rows of sum and max for
// left depths 1..CAPACITY; depth zero is the constant sum 0 / max minimum).
// Read rows are used only below the counts, so no clearing pass follows reset.
// Query with length zero returns the minimum 64-bit value; a query beyond
// the left count returns status range, a full insert returns status full.
module cursor_buffer_prefix_max_sum
  import cbpm_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  cbpm_req_if.sink   req_i,
  cbpm_res_if.source res_o
);

  localparam int CMP_W = (LEN_W > CNT_W) ? LEN_W : CNT_W;
  localparam int TOT_W = CNT_W + 1;

  // control state
  state_e           state_q, state_d;
  logic [CNT_W-1:0] lcount_q, lcount_d;
  logic [CNT_W-1:0] rcount_q, rcount_d;
  logic             out_valid_q, out_valid_d;

  // captured request
  logic [REQ_W-1:0] req_type_q;
  logic [VAL_W-1:0] value_q;
  logic [LEN_W-1:0] plen_q;

  // result payload
  logic signed [SUM_W-1:0] out_sum_q, out_sum_d;
  logic [STAT_W-1:0]       out_stat_q, out_stat_d;

  logic accept;
  logic exec_go;
  logic has_res;

  // ram ports
  logic              left_we, right_we, pfx_we;
  logic [ADDR_W-1:0] left_waddr, right_waddr, pfx_waddr;
  logic [VAL_W-1:0]  left_wdata, right_wdata;
  prefix_t           pfx_wdata;
  logic [ADDR_W-1:0] left_raddr, right_raddr, pfx_raddr;
  logic [VAL_W-1:0]  left_rdata, right_rdata;
  logic [PREFIX_W-1:0] pfx_rdata_raw;
  prefix_t           pfx_rdata;

  // datapath
  logic                    room, lc_zero, rc_zero, lc_full, rc_full;
  logic [CMP_W-1:0]        plen_ext, lc_ext;
  logic signed [SUM_W-1:0] sum_prev, max_prev, sum_new;
  logic [VAL_W-1:0]        push_val;
  logic                    do_push;

  assign req_i.ready = (state_q == S_IDLE);
  assign accept      = req_i.valid && req_i.ready;

  // reads issued at accept: counts are stable until the write-back cycle
  assign left_raddr  = ADDR_W'(lcount_q - CNT_W'(1));
  assign right_raddr = ADDR_W'(rcount_q - CNT_W'(1));
  assign pfx_raddr   = (req_i.req_type == REQ_QUERY) ?
                       ADDR_W'(req_i.prefix_len - LEN_W'(1)) :
                       ADDR_W'(lcount_q - CNT_W'(1));

  cbpm_ram #(.WIDTH(VAL_W), .DEPTH(CAPACITY)) u_left_ram (
    .clk_i   (clk_i),
    .we_i    (left_we),
    .waddr_i (left_waddr),
    .wdata_i (left_wdata),
    .re_i    (accept),
    .raddr_i (left_raddr),
    .rdata_o (left_rdata)
  );

  cbpm_ram #(.WIDTH(VAL_W), .DEPTH(CAPACITY)) u_right_ram (
    .clk_i   (clk_i),
    .we_i    (right_we),
    .waddr_i (right_waddr),
    .wdata_i (right_wdata),
    .re_i    (accept),
    .raddr_i (right_raddr),
    .rdata_o (right_rdata)
  );

  cbpm_ram #(.WIDTH(PREFIX_W), .DEPTH(CAPACITY)) u_pfx_ram (
    .clk_i   (clk_i),
    .we_i    (pfx_we),
    .waddr_i (pfx_waddr),
    .wdata_i (pfx_wdata),
    .re_i    (accept),
    .raddr_i (pfx_raddr),
    .rdata_o (pfx_rdata_raw)
  );

  assign pfx_rdata = prefix_t'(pfx_rdata_raw);

  // status flags of the current counts
  assign lc_zero  = (lcount_q == '0);
  assign rc_zero  = (rcount_q == '0);
  assign lc_full  = (lcount_q == CNT_W'(CAPACITY));
  assign rc_full  = (rcount_q == CNT_W'(CAPACITY));
  assign room     = (TOT_W'(lcount_q) + TOT_W'(rcount_q)) < TOT_W'(CAPACITY);
  assign plen_ext = CMP_W'(plen_q);
  assign lc_ext   = CMP_W'(lcount_q);

  // depth zero of the prefix table is constant, never stored
  assign sum_prev = lc_zero ? '0 : pfx_rdata.sum;
  assign max_prev = lc_zero ? SUM_MIN : pfx_rdata.max;

  // pushed element: new value on insert, right top on move right
  assign push_val = (req_type_q == REQ_RIGHT) ? right_rdata : value_q;
  assign sum_new  = sum_prev + {{(SUM_W-VAL_W){push_val[VAL_W-1]}}, push_val};

  assign has_res = (req_type_q == REQ_QUERY) || ((req_type_q == REQ_INSERT) && !room);
  assign exec_go = (state_q == S_EXEC) && (!has_res || !out_valid_q || res_o.ready);

  assign do_push = exec_go &&
                   (((req_type_q == REQ_INSERT) && room) ||
                    ((req_type_q == REQ_RIGHT) && !rc_zero && !lc_full));

  // write-back: push goes to left stack and prefix row at the old left depth
  assign left_we    = do_push;
  assign left_waddr = ADDR_W'(lcount_q);
  assign left_wdata = push_val;

  assign pfx_we        = do_push;
  assign pfx_waddr     = ADDR_W'(lcount_q);
  assign pfx_wdata.sum = sum_new;
  assign pfx_wdata.max = (sum_new > max_prev) ? sum_new : max_prev;

  assign right_we    = exec_go && (req_type_q == REQ_LEFT) && !lc_zero && !rc_full;
  assign right_waddr = ADDR_W'(rcount_q);
  assign right_wdata = left_rdata;

  // next state, counts and result
  always_comb begin
    state_d     = state_q;
    lcount_d    = lcount_q;
    rcount_d    = rcount_q;
    out_valid_d = out_valid_q;
    out_sum_d   = out_sum_q;
    out_stat_d  = out_stat_q;

    if (res_o.valid && res_o.ready) begin
      out_valid_d = 1'b0;
    end

    case (state_q)
      S_IDLE: begin
        if (accept) begin
          state_d = S_EXEC;
        end
      end
      S_EXEC: begin
        if (exec_go) begin
          state_d = S_IDLE;
          case (req_type_q)
            REQ_INSERT: begin
              if (room) begin
                lcount_d = lcount_q + CNT_W'(1);
              end else begin
                out_valid_d = 1'b1;
                out_sum_d   = '0;
                out_stat_d  = STAT_FULL;
              end
            end
            REQ_DELETE: begin
              if (!lc_zero) begin
                lcount_d = lcount_q - CNT_W'(1);
              end
            end
            REQ_LEFT: begin
              if (!lc_zero && !rc_full) begin
                lcount_d = lcount_q - CNT_W'(1);
                rcount_d = rcount_q + CNT_W'(1);
              end
            end
            REQ_RIGHT: begin
              if (!rc_zero && !lc_full) begin
                lcount_d = lcount_q + CNT_W'(1);
                rcount_d = rcount_q - CNT_W'(1);
              end
            end
            REQ_QUERY: begin
              out_valid_d = 1'b1;
              if (plen_ext > lc_ext) begin
                out_sum_d  = '0;
                out_stat_d = STAT_RANGE;
              end else if (plen_q == '0) begin
                out_sum_d  = SUM_MIN;
                out_stat_d = STAT_OK;
              end else begin
                out_sum_d  = pfx_rdata.max;
                out_stat_d = STAT_OK;
              end
            end
            default: begin
              // unused codes are dropped
            end
          endcase
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      lcount_q    <= '0;
      rcount_q    <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      lcount_q    <= lcount_d;
      rcount_q    <= rcount_d;
      out_valid_q <= out_valid_d;
    end
  end

  // request capture and result payload
  always_ff @(posedge clk_i) begin
    if (accept) begin
      req_type_q <= req_i.req_type;
      value_q    <= req_i.value;
      plen_q     <= req_i.prefix_len;
    end
    out_sum_q  <= out_sum_d;
    out_stat_q <= out_stat_d;
  end

  assign res_o.valid          = out_valid_q;
  assign res_o.max_prefix_sum = out_sum_q;
  assign res_o.status         = out_stat_q;

`ifndef SYNTHESIS
  // the two stacks never hold more than the capacity together
  a_capacity: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (TOT_W'(lcount_q) + TOT_W'(rcount_q)) <= TOT_W'(CAPACITY))
    else $error("stack counts exceed capacity");

  // an accepted beat is followed by the write-back cycle
  a_exec_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |=> (state_q == S_EXEC) && !req_i.ready)
    else $error("no write-back cycle after accept");

  // a finished query always leaves a result beat pending
  a_query_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (exec_go && (req_type_q == REQ_QUERY)) |=> res_o.valid)
    else $error("query finished without a result");

  // rams are written only in the write-back cycle
  a_write_window: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (left_we || right_we || pfx_we) |-> (state_q == S_EXEC))
    else $error("ram write outside write-back cycle");
`endif

endmodule

// ----- rtl/cbpm_ram.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cbpm_ram
// simple dual port ram, one write and one registered read port
// ----------------------------------------------------------------------------
module cbpm_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 1024,
  localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  // read data holds until the next read
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ----- tb/cursor_buffer_prefix_max_sum_tb.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cursor_buffer_prefix_max_sum_tb
// self-checking bench for the two-stack cursor buffer with prefix max sum
// ----------------------------------------------------------------------------
// A scoreboard class keeps its own copy of both stacks, the counts and the
// running sum / running max tables. Every request beat is folded into that
// copy as it is accepted; queries and dropped inserts queue an answer that
// the next result beat must match field by field. Stimulus runs as a short
// directed opener, a grow-biased random phase with a long receiver hold-off,
// a drain pause, a fill to capacity with full inserts, and a shrink-biased
// random phase. Both sides idle at random outside the fill and the hold-off.
module cursor_buffer_prefix_max_sum_tb;
  import cbpm_pkg::*;

  localparam int unsigned HALF_PERIOD    = 6;
  localparam int unsigned RESET_CYCLES   = 3;
  localparam int unsigned IDLE_PCT       = 22;
  localparam int unsigned HOLD_CYCLES    = 300;
  localparam int unsigned WATCHDOG_LIMIT = 4000;
  localparam int unsigned TAIL_CYCLES    = 8;
  localparam int unsigned PHASE_ITEMS    = 425;
  localparam int unsigned LEN_MAX        = (1 << LEN_W) - 1;

  // request codes the block ignores
  localparam logic [REQ_W-1:0] REQ_UNUSED_LO = 3'd5;
  localparam logic [REQ_W-1:0] REQ_UNUSED_HI = 3'd7;

  localparam logic [VAL_W-1:0] VAL_POS_MAX = 32'h7fff_ffff;
  localparam logic [VAL_W-1:0] VAL_NEG_MIN = 32'h8000_0000;
  localparam logic [VAL_W-1:0] VAL_NEG_ONE = 32'hffff_ffff;

  typedef struct {
    logic signed [SUM_W-1:0] sum;
    status_e                 status;
  } answer_t;

  // --------------------------------------------------------------------------
  // scoreboard: mirror of the editor state plus the queue of pending answers
  // --------------------------------------------------------------------------
  class prefix_scoreboard;
    logic [VAL_W-1:0]        left_mem  [CAPACITY];
    logic [VAL_W-1:0]        right_mem [CAPACITY];
    int unsigned             left_n;
    int unsigned             right_n;
    logic signed [SUM_W-1:0] run_sum [CAPACITY+1];
    logic signed [SUM_W-1:0] run_max [CAPACITY+1];
    answer_t                 answers_q [$];
    int unsigned             fail_count;

    function new();
      left_n     = 0;
      right_n    = 0;
      fail_count = 0;
      run_sum[0] = '0;
      run_max[0] = SUM_MIN;
    endfunction

    // push at the cursor and extend the running tables by one row
    function void push_left(logic [VAL_W-1:0] v);
      logic signed [SUM_W-1:0] s;
      left_mem[left_n]    = v;
      s                   = run_sum[left_n] + {{(SUM_W-VAL_W){v[VAL_W-1]}}, v};
      run_sum[left_n + 1] = s;
      run_max[left_n + 1] = (s > run_max[left_n]) ? s : run_max[left_n];
      left_n++;
    endfunction

    function void note_request(logic [REQ_W-1:0] op, logic [VAL_W-1:0] val,
                               logic [LEN_W-1:0] len);
      answer_t a;
      case (op)
        REQ_INSERT: begin
          if (left_n + right_n >= CAPACITY) begin
            a.sum    = '0;
            a.status = STAT_FULL;
            answers_q.insert(answers_q.size(), a);
          end else begin
            push_left(val);
          end
        end
        REQ_DELETE: begin
          if (left_n > 0) left_n--;
        end
        REQ_LEFT: begin
          if (left_n > 0 && right_n < CAPACITY) begin
            left_n--;
            right_mem[right_n] = left_mem[left_n];
            right_n++;
          end
        end
        REQ_RIGHT: begin
          if (right_n > 0 && left_n < CAPACITY) begin
            right_n--;
            push_left(right_mem[right_n]);
          end
        end
        REQ_QUERY: begin
          if (len > left_n) begin
            a.sum    = '0;
            a.status = STAT_RANGE;
          end else begin
            a.sum    = run_max[len];
            a.status = STAT_OK;
          end
          answers_q.insert(answers_q.size(), a);
        end
        default: ;
      endcase
    endfunction

    function void check_result(logic signed [SUM_W-1:0] sum, logic [STAT_W-1:0] status);
      answer_t a;
      if (answers_q.size() == 0) begin
        $display("%0t: unexpected result beat: sum %0d status %0d", $time, sum, status);
        fail_count++;
        return;
      end
      a = answers_q.pop_front();
      if (sum !== a.sum) begin
        $display("%0t: max_prefix_sum mismatch: expected %0d actual %0d",
                 $time, a.sum, sum);
        fail_count++;
      end
      if (status !== a.status) begin
        $display("%0t: status mismatch: expected %0d actual %0d",
                 $time, a.status, status);
        fail_count++;
      end
    endfunction
  endclass

  // --------------------------------------------------------------------------
  // clock, reset, channels and the block
  // --------------------------------------------------------------------------
  logic clk_i = 1'b0;
  logic rst_ni;

  cbpm_req_if req_if ();
  cbpm_res_if res_if ();

  cursor_buffer_prefix_max_sum u_top (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (req_if),
    .res_o  (res_if)
  );

  always #HALF_PERIOD clk_i = ~clk_i;

  prefix_scoreboard sb = new();

  // idling controls of the sender and the receiver, and the watchdog count
  bit          tx_steady;
  bit          rx_steady;
  bit          hold_off_pending;
  int unsigned stall_cycles;

  // --------------------------------------------------------------------------
  // monitor: note request beats before checking result beats, plus watchdog
  // --------------------------------------------------------------------------
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (req_if.valid && req_if.ready)
        sb.note_request(req_if.req_type, req_if.value, req_if.prefix_len);
      if (res_if.valid && res_if.ready)
        sb.check_result(res_if.max_prefix_sum, res_if.status);
      // progress means a beat moved on either channel
      if ((req_if.valid && req_if.ready) || (res_if.valid && res_if.ready))
        stall_cycles = 0;
      else
        stall_cycles++;
      if (stall_cycles >= WATCHDOG_LIMIT) begin
        $display("%0t: no beat moved for %0d cycles", $time, stall_cycles);
        $display("cursor_buffer_prefix_max_sum_tb: FAIL");
        $finish;
      end
    end
  end

  // --------------------------------------------------------------------------
  // receiver: random back-pressure, steady stretches and one long hold-off
  // --------------------------------------------------------------------------
  initial begin
    res_if.ready <= 1'b0;
    @(posedge rst_ni);
    forever begin
      @(posedge clk_i);
      if (hold_off_pending) begin
        // hold off long enough that the result register and input both stall
        hold_off_pending = 1'b0;
        res_if.ready <= 1'b0;
        repeat (HOLD_CYCLES - 1) @(posedge clk_i);
      end else if (rx_steady) begin
        res_if.ready <= 1'b1;
      end else begin
        res_if.ready <= ($urandom_range(99) >= IDLE_PCT);
      end
    end
  end

  // --------------------------------------------------------------------------
  // sender tasks
  // --------------------------------------------------------------------------
  // one request beat, preceded by a random gap unless the sender is steady
  task automatic send_beat(input logic [REQ_W-1:0] op, input logic [VAL_W-1:0] val,
                           input logic [LEN_W-1:0] len);
    if (!tx_steady) begin
      while ($urandom_range(99) < IDLE_PCT) begin
        req_if.valid <= 1'b0;
        @(posedge clk_i);
      end
    end
    req_if.valid      <= 1'b1;
    req_if.req_type   <= op;
    req_if.value      <= val;
    req_if.prefix_len <= len;
    do @(posedge clk_i); while (!req_if.ready);
  endtask

  // random operation; shrink mode favors deletes, otherwise inserts
  task automatic send_random_op(input bit shrink, output bit counted);
    int unsigned      pick;
    logic [REQ_W-1:0] op;
    logic [VAL_W-1:0] val;
    logic [LEN_W-1:0] len;
    pick = $urandom_range(99);
    if (shrink) begin
      if (pick < 20)      op = REQ_INSERT;
      else if (pick < 55) op = REQ_DELETE;
      else if (pick < 65) op = REQ_LEFT;
      else if (pick < 73) op = REQ_RIGHT;
      else if (pick < 95) op = REQ_QUERY;
      else op = REQ_UNUSED_LO + REQ_W'($urandom_range(REQ_UNUSED_HI - REQ_UNUSED_LO));
    end else begin
      if (pick < 40)      op = REQ_INSERT;
      else if (pick < 48) op = REQ_DELETE;
      else if (pick < 60) op = REQ_LEFT;
      else if (pick < 70) op = REQ_RIGHT;
      else if (pick < 95) op = REQ_QUERY;
      else op = REQ_UNUSED_LO + REQ_W'($urandom_range(REQ_UNUSED_HI - REQ_UNUSED_LO));
    end
    // mostly full-range values, now and then the signed extremes
    case ($urandom_range(19))
      0:       val = VAL_POS_MAX;
      1:       val = VAL_NEG_MIN;
      default: val = $urandom;
    endcase
    // lengths mostly within the left count, sometimes over the whole field
    if ($urandom_range(4) == 0) len = LEN_W'($urandom_range(LEN_MAX));
    else                        len = LEN_W'($urandom_range(sb.left_n));
    send_beat(op, val, len);
    counted = (op < REQ_UNUSED_LO);
  endtask

  // stop offering and wait until every pending answer has come back
  task automatic wait_for_answers();
    req_if.valid <= 1'b0;
    @(posedge clk_i);
    while (sb.answers_q.size() != 0) @(posedge clk_i);
  endtask

  // --------------------------------------------------------------------------
  // main sequence
  // --------------------------------------------------------------------------
  initial begin
    int unsigned n;
    bit          counted;

    tx_steady         = 1'b0;
    rx_steady         = 1'b0;
    hold_off_pending  = 1'b0;
    stall_cycles      = 0;
    rst_ni            <= 1'b0;
    req_if.valid      <= 1'b0;
    req_if.req_type   <= REQ_INSERT;
    req_if.value      <= '0;
    req_if.prefix_len <= '0;
    repeat (RESET_CYCLES) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed opener: empty buffer corner cases
    send_beat(REQ_QUERY, '0, '0);            // length zero gives the minimum
    send_beat(REQ_QUERY, '0, 11'd1);         // beyond an empty left side
    send_beat(REQ_DELETE, '0, '0);           // ignored at the start
    send_beat(REQ_LEFT, '0, '0);             // ignored at the start
    send_beat(REQ_RIGHT, '0, '0);            // ignored at the end

    // signed extremes and small values
    send_beat(REQ_INSERT, VAL_POS_MAX, '0);
    send_beat(REQ_INSERT, VAL_NEG_MIN, '0);
    send_beat(REQ_INSERT, VAL_NEG_ONE, '0);
    send_beat(REQ_INSERT, '0, '0);
    send_beat(REQ_INSERT, 32'd1, '0);
    send_beat(REQ_QUERY, '0, 11'd1);
    send_beat(REQ_QUERY, '0, 11'd3);
    send_beat(REQ_QUERY, '0, 11'd5);
    send_beat(REQ_QUERY, '0, 11'd6);         // one past the left count
    send_beat(REQ_QUERY, '0, LEN_W'(LEN_MAX));

    // cursor moves rebuild the prefix rows on the way back
    send_beat(REQ_LEFT, '0, '0);
    send_beat(REQ_LEFT, '0, '0);
    send_beat(REQ_QUERY, '0, 11'd3);
    send_beat(REQ_DELETE, '0, '0);
    send_beat(REQ_QUERY, '0, 11'd3);         // left count dropped to two
    send_beat(REQ_RIGHT, '0, '0);
    send_beat(REQ_RIGHT, '0, '0);
    send_beat(REQ_RIGHT, '0, '0);            // already at the end
    send_beat(REQ_QUERY, '0, 11'd4);

    // unused codes with random payload
    for (logic [REQ_W-1:0] c = REQ_UNUSED_LO; c <= REQ_UNUSED_HI && c >= REQ_UNUSED_LO; c++)
      send_beat(c, $urandom, LEN_W'($urandom_range(LEN_MAX)));

    // grow-biased random phase with one long receiver hold-off in the middle
    n = 0;
    while (n < PHASE_ITEMS) begin
      if (n == PHASE_ITEMS / 2) begin
        hold_off_pending = 1'b1;
        tx_steady        = 1'b1;
        repeat (12) send_beat(REQ_QUERY, $urandom, LEN_W'($urandom_range(sb.left_n)));
        tx_steady = 1'b0;
        n += 12;
      end
      send_random_op(1'b0, counted);
      if (counted) n++;
    end

    // sender pause until every answer is back
    wait_for_answers();

    // fill to capacity with no idling on either side, then hit the full cases
    tx_steady = 1'b1;
    rx_steady = 1'b1;
    while (sb.left_n + sb.right_n < CAPACITY) send_beat(REQ_INSERT, $urandom, '0);
    repeat (3) send_beat(REQ_INSERT, $urandom, '0);
    send_beat(REQ_QUERY, '0, LEN_W'(CAPACITY));
    send_beat(REQ_QUERY, '0, LEN_W'(CAPACITY + 1));
    send_beat(REQ_LEFT, '0, '0);
    send_beat(REQ_INSERT, VAL_NEG_MIN, '0);  // still full with the cursor moved
    send_beat(REQ_QUERY, '0, LEN_W'(CAPACITY - 1));
    send_beat(REQ_RIGHT, '0, '0);
    send_beat(REQ_RIGHT, '0, '0);            // right side empty again
    send_beat(REQ_QUERY, '0, LEN_W'(CAPACITY));
    tx_steady = 1'b0;
    rx_steady = 1'b0;

    // shrink-biased random phase from a full buffer
    n = 0;
    while (n < PHASE_ITEMS) begin
      send_random_op(1'b1, counted);
      if (counted) n++;
    end

    wait_for_answers();
    repeat (TAIL_CYCLES) @(posedge clk_i);

    if (sb.fail_count == 0)
      $display("cursor_buffer_prefix_max_sum_tb: PASS");
    else
      $display("cursor_buffer_prefix_max_sum_tb: FAIL");
    $finish;
  end

endmodule

// ----- cursor_buffer_prefix_max_sum.f -----
rtl/cbpm_pkg.sv
rtl/cbpm_req_if.sv
rtl/cbpm_res_if.sv
rtl/cbpm_ram.sv
rtl/cursor_buffer_prefix_max_sum.sv
tb/cursor_buffer_prefix_max_sum_tb.sv
